// ===== rtl/dvfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dvfs_pkg
// Shared types and constants for the DVFS frequency governor.
// ----------------------------------------------------------------------------
package dvfs_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 32;

  // Field widths fixed by the interface.
  localparam int HZ_W    = 32;
  localparam int LOAD_W  = 10;
  localparam int STEP_W  = 11;
  localparam int HOLD_W  = 7;
  localparam int COUNT_W = 6;
  localparam int DIV_W   = HZ_W + LOAD_W;

  // Register reset values and legal bounds.
  localparam logic [STEP_W-1:0] STEP_UTIL_RESET   = 11'd900;
  localparam logic [STEP_W-1:0] STEP_UTIL_MIN     = 11'd100;
  localparam logic [STEP_W-1:0] STEP_UTIL_MAX     = 11'd1500;
  localparam logic [HOLD_W-1:0] HOLD_DEFAULT      = 7'd10;
  localparam logic [HOLD_W-1:0] HOLD_MAX          = 7'd100;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_STEP_UTIL   = 2'd0;
  localparam logic [1:0] REG_DOWN_HOLD   = 2'd1;
  localparam logic [1:0] REG_TABLE_COUNT = 2'd2;

  // Input item kinds.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDMAX,
    ST_MUL,
    ST_DIV,
    ST_CAP,
    ST_CLAMP,
    ST_SCAN_ADDR,
    ST_SCAN_CMP,
    ST_FINAL,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/dvfs_frequency_governor.sv =====
// ----------------------------------------------------------------------------
// dvfs_frequency_governor
// Table-driven DVFS governor: load to frequency, caps, table search,
// down-step hold and floor.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// in_       slave      tvalid/tready        tuser: func; tdata: tick or write
// out_      master     tvalid/tready        tdata: apply, freq, going_down, hold
// cfg_      APB        psel/penable/pready  step_util, down_hold_ticks, count
//
// A table write or an inactive tick goes from acceptance straight to the output
// state, which loads the output register once that register is free. An active
// tick reads the table maximum, multiplies it by the load, divides the 42-bit
// product in the bit-serial divider, applies the caps, then searches k entries
// (1 to table_count) through the registered read port of the table memory and
// takes the final step before the output state. A new item is taken only in idle.
// Reset is synchronous and clears the control state and registers; table
// contents are undefined until written. A result waiting in the output register
// does not block acceptance of the next item; a second result waits until the
// first one is taken.
// ----------------------------------------------------------------------------
module dvfs_frequency_governor #(
  parameter int TABLE_DEPTH = dvfs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,

  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata, from bit 0: entry_index[4:0], entry_hz[36:5], active[37],
  // load[47:38], target_hz[79:48], limit_hz[111:80], floor_hz[143:112],
  // assignable[144], zero fill to 152 bits.
  input  logic [151:0] in_tdata,
  // tuser, from bit 0: func.
  input  logic [0:0]   in_tuser,

  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata, from bit 0: apply[0], freq_hz[32:1], going_down[33],
  // hold_left[40:34], zero fill to 48 bits.
  output logic [47:0]  out_tdata,

  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HW  = dvfs_pkg::HZ_W;
  localparam int LW  = dvfs_pkg::LOAD_W;
  localparam int SW  = dvfs_pkg::STEP_W;
  localparam int KW  = dvfs_pkg::HOLD_W;
  localparam int NW  = dvfs_pkg::COUNT_W;
  localparam int DW  = dvfs_pkg::DIV_W;

  // Input field unpacking.
  logic          in_func;
  logic [4:0]    in_entry_index;
  logic [HW-1:0] in_entry_hz;
  logic          in_active;
  logic [LW-1:0] in_load;
  logic [HW-1:0] in_target_hz;
  logic [HW-1:0] in_limit_hz;
  logic [HW-1:0] in_floor_hz;
  logic          in_assignable;

  assign in_func        = in_tuser[0];
  assign in_entry_index = in_tdata[4:0];
  assign in_entry_hz    = in_tdata[36:5];
  assign in_active      = in_tdata[37];
  assign in_load        = in_tdata[47:38];
  assign in_target_hz   = in_tdata[79:48];
  assign in_limit_hz    = in_tdata[111:80];
  assign in_floor_hz    = in_tdata[143:112];
  assign in_assignable  = in_tdata[144];

  // --------------------------------------------------------------------------
  // Configuration registers. Illegal values are replaced on the write.
  // --------------------------------------------------------------------------
  logic [SW-1:0] step_util_r;
  logic [KW-1:0] down_hold_r;
  logic [NW-1:0] table_count_r;
  logic          cfg_wr;
  logic [SW-1:0] wr_step;
  logic [KW-1:0] wr_hold;
  logic [NW-1:0] wr_count;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wr_step    = cfg_pwdata[SW-1:0];
  assign wr_hold    = cfg_pwdata[KW-1:0];
  assign wr_count   = cfg_pwdata[NW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_util_r   <= dvfs_pkg::STEP_UTIL_RESET;
      down_hold_r   <= dvfs_pkg::HOLD_DEFAULT;
      table_count_r <= NW'(1);
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        dvfs_pkg::REG_STEP_UTIL: begin
          if (wr_step < dvfs_pkg::STEP_UTIL_MIN || wr_step > dvfs_pkg::STEP_UTIL_MAX) begin
            step_util_r <= dvfs_pkg::STEP_UTIL_RESET;
          end else begin
            step_util_r <= wr_step;
          end
        end
        dvfs_pkg::REG_DOWN_HOLD: begin
          if (wr_hold > dvfs_pkg::HOLD_MAX) begin
            down_hold_r <= dvfs_pkg::HOLD_DEFAULT;
          end else begin
            down_hold_r <= wr_hold;
          end
        end
        dvfs_pkg::REG_TABLE_COUNT: begin
          if (wr_count == '0) begin
            table_count_r <= NW'(1);
          end else if (32'(wr_count) > TABLE_DEPTH) begin
            table_count_r <= NW'(TABLE_DEPTH);
          end else begin
            table_count_r <= wr_count;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      dvfs_pkg::REG_STEP_UTIL:   cfg_prdata = {{(32-SW){1'b0}}, step_util_r};
      dvfs_pkg::REG_DOWN_HOLD:   cfg_prdata = {{(32-KW){1'b0}}, down_hold_r};
      dvfs_pkg::REG_TABLE_COUNT: cfg_prdata = {{(32-NW){1'b0}}, table_count_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers.
  // --------------------------------------------------------------------------
  dvfs_pkg::state_t state_r, state_nxt;

  logic          in_acc;
  logic          out_free;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] last_idx;
  logic          div_start;
  logic [DW-1:0] div_quo;
  logic          div_done;

  logic [HW-1:0] mem [TABLE_DEPTH];
  logic [HW-1:0] rd_data_r;

  logic [LW-1:0] load_r;
  logic [HW-1:0] target_r;
  logic [HW-1:0] limit_r;
  logic [HW-1:0] floor_r;
  logic          assignable_r;
  logic [HW-1:0] tmax_r;
  logic [HW-1:0] desired_r;
  logic [HW-1:0] sel_r;
  logic [AW-1:0] scan_idx_r;

  logic [HW-1:0] last_hz_r;
  logic [KW-1:0] hold_r;

  logic          res_apply_r;
  logic [HW-1:0] res_freq_r;
  logic          res_down_r;
  logic [KW-1:0] res_hold_r;

  logic          out_valid_r;
  logic [47:0]   out_data_r;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign last_idx = AW'(table_count_r - NW'(1));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dvfs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_func == dvfs_pkg::FUNC_WRITE || !in_active) begin
            state_nxt = dvfs_pkg::ST_OUT;
          end else begin
            state_nxt = dvfs_pkg::ST_RDMAX;
          end
        end
      end
      dvfs_pkg::ST_RDMAX:     state_nxt = dvfs_pkg::ST_MUL;
      dvfs_pkg::ST_MUL:       state_nxt = dvfs_pkg::ST_DIV;
      dvfs_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = dvfs_pkg::ST_CAP;
        end
      end
      dvfs_pkg::ST_CAP:       state_nxt = dvfs_pkg::ST_CLAMP;
      dvfs_pkg::ST_CLAMP:     state_nxt = dvfs_pkg::ST_SCAN_ADDR;
      dvfs_pkg::ST_SCAN_ADDR: state_nxt = dvfs_pkg::ST_SCAN_CMP;
      dvfs_pkg::ST_SCAN_CMP: begin
        if (rd_data_r >= desired_r || scan_idx_r == last_idx) begin
          state_nxt = dvfs_pkg::ST_FINAL;
        end else begin
          state_nxt = dvfs_pkg::ST_SCAN_ADDR;
        end
      end
      dvfs_pkg::ST_FINAL:     state_nxt = dvfs_pkg::ST_OUT;
      dvfs_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = dvfs_pkg::ST_IDLE;
        end
      end
      default:                state_nxt = dvfs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    rd_addr   = scan_idx_r;
    div_start = 1'b0;
    case (state_r)
      dvfs_pkg::ST_IDLE:  in_tready = 1'b1;
      dvfs_pkg::ST_RDMAX: rd_addr   = last_idx;
      dvfs_pkg::ST_MUL:   div_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dvfs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Table memory: one write port for table items, one registered read port.
  always_ff @(posedge clk) begin
    if (in_acc && in_func == dvfs_pkg::FUNC_WRITE && 32'(in_entry_index) < TABLE_DEPTH) begin
      mem[AW'(in_entry_index)] <= in_entry_hz;
    end
    rd_data_r <= mem[rd_addr];
  end

  // The product of the table maximum and the load is registered inside
  // the divider on the start cycle.
  dvfs_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({{LW{1'b0}}, rd_data_r} * {{HW{1'b0}}, load_r}),
    .divisor  (step_util_r),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Final step values: hold countdown, floor and apply decision.
  logic          fin_down;
  logic [KW-1:0] fin_hold_arm;
  logic [KW-1:0] fin_hold;
  logic [HW-1:0] fin_freq;
  logic          fin_apply;

  always_comb begin
    fin_down = (last_hz_r != '0) && (sel_r < last_hz_r);
    if (!fin_down) begin
      fin_hold_arm = '0;
    end else if (hold_r == '0) begin
      fin_hold_arm = down_hold_r;
    end else begin
      fin_hold_arm = hold_r;
    end
    fin_hold  = (fin_hold_arm != '0) ? fin_hold_arm - KW'(1) : '0;
    fin_freq  = (sel_r < floor_r) ? floor_r : sel_r;
    fin_apply = (!fin_down || fin_hold == '0) && assignable_r;
  end

  // Governor state: hold counter and last applied frequency.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r    <= '0;
      last_hz_r <= '0;
    end else if (state_r == dvfs_pkg::ST_IDLE && in_acc
                 && in_func == dvfs_pkg::FUNC_TICK && !in_active) begin
      hold_r    <= '0;
      last_hz_r <= '0;
    end else if (state_r == dvfs_pkg::ST_FINAL) begin
      hold_r <= fin_hold;
      if (fin_apply) begin
        last_hz_r <= fin_freq;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    case (state_r)
      dvfs_pkg::ST_IDLE: begin
        if (in_acc) begin
          load_r       <= in_load;
          target_r     <= in_target_hz;
          limit_r      <= in_limit_hz;
          floor_r      <= in_floor_hz;
          assignable_r <= in_assignable;
          // Writes, inactive ticks: zero result, but writes report hold_r.
          res_apply_r  <= 1'b0;
          res_freq_r   <= '0;
          res_down_r   <= 1'b0;
          res_hold_r   <= (in_func == dvfs_pkg::FUNC_WRITE) ? hold_r : '0;
        end
      end
      dvfs_pkg::ST_MUL: begin
        tmax_r <= rd_data_r;
      end
      dvfs_pkg::ST_CAP: begin
        if (div_quo > {{LW{1'b0}}, tmax_r}) begin
          desired_r <= tmax_r;
        end else begin
          desired_r <= div_quo[HW-1:0];
        end
      end
      dvfs_pkg::ST_CLAMP: begin
        // The target cap applies first, then the limit cap; zero means none.
        if (target_r != '0 && desired_r > target_r) begin
          desired_r <= (limit_r != '0 && target_r > limit_r) ? limit_r : target_r;
        end else if (limit_r != '0 && desired_r > limit_r) begin
          desired_r <= limit_r;
        end
        scan_idx_r <= '0;
      end
      dvfs_pkg::ST_SCAN_CMP: begin
        if (rd_data_r >= desired_r) begin
          sel_r <= rd_data_r;
        end else if (scan_idx_r == last_idx) begin
          sel_r <= tmax_r;
        end else begin
          scan_idx_r <= scan_idx_r + AW'(1);
        end
      end
      dvfs_pkg::ST_FINAL: begin
        res_apply_r <= fin_apply;
        res_freq_r  <= fin_freq;
        res_down_r  <= fin_down;
        res_hold_r  <= fin_hold;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == dvfs_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (state_r == dvfs_pkg::ST_OUT && out_free) begin
      out_data_r <= {7'd0, res_hold_r, res_down_r, res_freq_r, res_apply_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/dvfs_div.sv =====
// ----------------------------------------------------------------------------
// dvfs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dvfs_div #(
  parameter int DW = dvfs_pkg::DIV_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [dvfs_pkg::STEP_W-1:0] divisor,
  output logic [DW-1:0]              quotient,
  output logic                       done
);

  localparam int SW  = dvfs_pkg::STEP_W;
  localparam int CW  = $clog2(DW + 1);

  logic [SW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [SW:0]   cat;
  logic [SW+1:0] diff;

  assign cat  = {rem_r, quo_r[DW-1]};
  assign diff = {1'b0, cat} - {2'b00, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits in SW bits.
      if (!diff[SW+1]) begin
        rem_nxt = diff[SW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = cat[SW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
